// File: sv/lru_key_value_cache_defines.svh
// ----------------------------------------------------------------------------
// lru key/value cache assertion macros
// concurrent check wrappers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication check
`define LKVC_ASSERT_IMP(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("lkvc check failed");
// next-cycle implication check
`define LKVC_ASSERT_NXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("lkvc check failed");
`else
`define LKVC_ASSERT_IMP(label, ck, rn, ante, cons)
`define LKVC_ASSERT_NXT(label, ck, rn, ante, cons)
`endif

`endif

// File: sv/lkvc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_pkg
// shared types and constants of the lru key/value cache
// ----------------------------------------------------------------------------
package lkvc_pkg;

    // field widths
    localparam int KEY_W = 32;
    localparam int VAL_W = 32;
    localparam int CAP_W = 5;
    localparam int CMP_W = 32;

    // defaults
    localparam int         DEPTH_DEF = 16;
    localparam logic [4:0] CAP_RESET = 5'd16;

    // request codes
    localparam logic CMD_GET = 1'b0;
    localparam logic CMD_PUT = 1'b1;

    // data returned on a miss
    localparam logic [VAL_W-1:0] MISS_DATA = '1;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_TOUCH,
        ST_EVCHK,
        ST_VFIND,
        ST_VREAD,
        ST_VCOPY,
        ST_BUMP,
        ST_INSERT,
        ST_DONE
    } state_t;

    // flags from the shared compare unit
    typedef struct packed {
        logic eq;
        logic lt;
    } cmp_res_t;

endpackage

// File: sv/lkvc_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module lkvc_ram #(
    parameter int W = 32,
    parameter int D = 16
) (
    input  logic                              clk,
    input  logic                              we,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
    input  logic [W-1:0]                      wdata,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
    output logic [W-1:0]                      rdata
);

    logic [W-1:0] mem [D];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// File: sv/lkvc_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkvc_cmp
// shared compare unit: equality and unsigned less-than of two words
// ----------------------------------------------------------------------------
module lkvc_cmp
    import lkvc_pkg::*;
(
    input  logic [CMP_W-1:0] a,
    input  logic [CMP_W-1:0] b,
    output cmp_res_t         res
);

    // one comparator pair serves key match, rank match and rank order
    always_comb
    begin
        res.eq = (a == b);
        res.lt = (a < b);
    end

endmodule

// File: sv/lru_key_value_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_key_value_cache
// key/value store with least-recently-used replacement
// ----------------------------------------------------------------------------
// With N entries stored, a request walks the key, value and rank rams one
// entry a cycle through their single registered read port, judged by one
// shared compare unit. A get miss runs the lookup scan and then its result
// stage; a get hit adds a rank update pass between the two, and a put of a
// known key runs the lookup and the rank update pass, as it has no result
// stage. A put of a new key follows its lookup with a room check, then per
// eviction a victim scan, a read of the last entry, a copy of it into the
// victim slot and another room check, then a rank bump over the entries left
// (skipped when none are left) and an insert. With a zero capacity a get goes
// straight to its result stage and a put is dropped without a lookup. The
// block takes one request at a time; a get result sits in an output register,
// so the next request can be accepted while it waits, and a get holds in its
// result stage only while the previous result is still unread. No clearing
// pass runs after reset.
// ----------------------------------------------------------------------------
`include "lru_key_value_cache_defines.svh"

module lru_key_value_cache
    import lkvc_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    // configuration
    input  logic             cfg_we,
    input  logic [CAP_W-1:0] cfg_wdata,
    // request channel
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             cmd,
    input  logic [KEY_W-1:0] key,
    input  logic [VAL_W-1:0] value,
    // result channel
    output logic             out_valid,
    input  logic             out_ready,
    output logic             hit,
    output logic [VAL_W-1:0] data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW = AW;
    localparam int CW = $clog2(DEPTH + 1);

    // control state
    state_t           state_reg, state_next;
    logic [CAP_W-1:0] capacity_reg;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic             pv_reg, pv_next;
    logic             found_reg, found_next;
    logic             out_valid_reg, out_valid_next;

    // payload state
    logic             cmd_reg, cmd_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [VAL_W-1:0] value_reg, value_next;
    logic [AW-1:0]    pidx_reg, pidx_next;
    logic [AW-1:0]    slot_reg, slot_next;
    logic [RW-1:0]    frank_reg, frank_next;
    logic [VAL_W-1:0] fval_reg, fval_next;
    logic             hit_reg, hit_next;
    logic [VAL_W-1:0] data_reg, data_next;

    // ram ports
    logic [AW-1:0]    rd_addr, wr_addr;
    logic             key_we, val_we, rank_we;
    logic [KEY_W-1:0] key_wdata, key_rd;
    logic [VAL_W-1:0] val_wdata, val_rd;
    logic [RW-1:0]    rank_wdata, rank_rd;

    // compare unit
    logic [CMP_W-1:0] cmp_a, cmp_b;
    cmp_res_t         cmp_res;

    // misc
    logic [CW-1:0]    cap_eff;
    logic [RW-1:0]    rank_tgt;
    logic             issue;
    logic             match;
    logic             scan_state;
    logic             in_take;
    logic             out_free;

    // capacity saturates at the store depth
    assign cap_eff = ({{(CMP_W - CAP_W){1'b0}}, capacity_reg} > CMP_W'(DEPTH))
                   ? CW'(DEPTH) : CW'(capacity_reg);

    assign rank_tgt = RW'(count_reg - CW'(1));
    assign issue    = (idx_reg < count_reg);
    assign match    = pv_reg && cmp_res.eq;
    assign in_take  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign scan_state = (state_reg == ST_SEARCH) || (state_reg == ST_TOUCH) ||
                        (state_reg == ST_VFIND)  || (state_reg == ST_BUMP);

    // storage
    lkvc_ram #(.W(KEY_W), .D(DEPTH)) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (wr_addr),
        .wdata (key_wdata),
        .raddr (rd_addr),
        .rdata (key_rd)
    );

    lkvc_ram #(.W(VAL_W), .D(DEPTH)) u_val_ram (
        .clk   (clk),
        .we    (val_we),
        .waddr (wr_addr),
        .wdata (val_wdata),
        .raddr (rd_addr),
        .rdata (val_rd)
    );

    lkvc_ram #(.W(RW), .D(DEPTH)) u_rank_ram (
        .clk   (clk),
        .we    (rank_we),
        .waddr (wr_addr),
        .wdata (rank_wdata),
        .raddr (rd_addr),
        .rdata (rank_rd)
    );

    lkvc_cmp u_cmp (
        .a   (cmp_a),
        .b   (cmp_b),
        .res (cmp_res)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (cap_eff == '0)
                    begin
                        state_next = (cmd == CMD_GET) ? ST_DONE : ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH:
            begin
                if (match)
                begin
                    state_next = ST_TOUCH;
                end
                else if (!issue)
                begin
                    state_next = (cmd_reg == CMD_GET) ? ST_DONE : ST_EVCHK;
                end
            end
            ST_TOUCH:
            begin
                if (!issue)
                begin
                    state_next = (cmd_reg == CMD_GET) ? ST_DONE : ST_IDLE;
                end
            end
            ST_EVCHK:
            begin
                if (count_reg >= cap_eff)
                begin
                    state_next = ST_VFIND;
                end
                else if (count_reg == '0)
                begin
                    state_next = ST_INSERT;
                end
                else
                begin
                    state_next = ST_BUMP;
                end
            end
            ST_VFIND:
            begin
                if (match || (!issue && !pv_reg))
                begin
                    state_next = ST_VREAD;
                end
            end
            ST_VREAD:  state_next = ST_VCOPY;
            ST_VCOPY:  state_next = ST_EVCHK;
            ST_BUMP:
            begin
                if (!issue)
                begin
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT: state_next = ST_IDLE;
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs: ram controls and compare operands
    always_comb
    begin
        in_ready   = (state_reg == ST_IDLE);
        rd_addr    = idx_reg[AW-1:0];
        wr_addr    = pidx_reg;
        key_we     = 1'b0;
        val_we     = 1'b0;
        rank_we    = 1'b0;
        key_wdata  = key_rd;
        val_wdata  = val_rd;
        rank_wdata = rank_rd;
        cmp_a      = '0;
        cmp_b      = '0;
        unique case (state_reg)
            ST_SEARCH:
            begin
                cmp_a     = key_rd;
                cmp_b     = key_reg;
                // put hit rewrites the value in place
                val_we    = match && (cmd_reg == CMD_PUT);
                val_wdata = value_reg;
            end
            ST_TOUCH:
            begin
                cmp_a   = {{(CMP_W - RW){1'b0}}, rank_rd};
                cmp_b   = {{(CMP_W - RW){1'b0}}, frank_reg};
                rank_we = pv_reg;
                if (pidx_reg == slot_reg)
                begin
                    rank_wdata = '0;
                end
                else if (cmp_res.lt)
                begin
                    rank_wdata = rank_rd + RW'(1);
                end
                else
                begin
                    rank_wdata = rank_rd;
                end
            end
            ST_VFIND:
            begin
                cmp_a = {{(CMP_W - RW){1'b0}}, rank_rd};
                cmp_b = {{(CMP_W - RW){1'b0}}, rank_tgt};
            end
            ST_VREAD:
            begin
                rd_addr = rank_tgt[AW-1:0];
            end
            ST_VCOPY:
            begin
                // last entry moves into the victim slot
                wr_addr = slot_reg;
                key_we  = 1'b1;
                val_we  = 1'b1;
                rank_we = 1'b1;
            end
            ST_BUMP:
            begin
                rank_we    = pv_reg;
                rank_wdata = rank_rd + RW'(1);
            end
            ST_INSERT:
            begin
                wr_addr    = count_reg[AW-1:0];
                key_we     = 1'b1;
                val_we     = 1'b1;
                rank_we    = 1'b1;
                key_wdata  = key_reg;
                val_wdata  = value_reg;
                rank_wdata = '0;
            end
            ST_IDLE, ST_EVCHK, ST_DONE:
            begin
                rd_addr = idx_reg[AW-1:0];
            end
            default:
            begin
                rd_addr = idx_reg[AW-1:0];
            end
        endcase
    end

    // datapath next values
    always_comb
    begin
        cmd_next       = cmd_reg;
        key_next       = key_reg;
        value_next     = value_reg;
        count_next     = count_reg;
        found_next     = found_reg;
        slot_next      = slot_reg;
        frank_next     = frank_reg;
        fval_next      = fval_reg;
        hit_next       = hit_reg;
        data_next      = data_reg;
        out_valid_next = out_valid_reg && !out_ready;

        // scan pointer advances only while a scan state holds
        if (scan_state && (state_next == state_reg))
        begin
            idx_next  = issue ? (idx_reg + CW'(1)) : idx_reg;
            pv_next   = issue;
            pidx_next = idx_reg[AW-1:0];
        end
        else
        begin
            idx_next  = '0;
            pv_next   = 1'b0;
            pidx_next = pidx_reg;
        end

        // capture request
        if ((state_reg == ST_IDLE) && in_take)
        begin
            cmd_next   = cmd;
            key_next   = key;
            value_next = value;
            found_next = 1'b0;
        end

        // key found
        if ((state_reg == ST_SEARCH) && match)
        begin
            found_next = 1'b1;
            slot_next  = pidx_reg;
            frank_next = rank_rd;
            fval_next  = val_rd;
        end

        // victim found
        if ((state_reg == ST_VFIND) && match)
        begin
            slot_next = pidx_reg;
        end

        // entry count
        if (state_reg == ST_VCOPY)
        begin
            count_next = count_reg - CW'(1);
        end
        else if (state_reg == ST_INSERT)
        begin
            count_next = count_reg + CW'(1);
        end

        // result register
        if ((state_reg == ST_DONE) && out_free)
        begin
            out_valid_next = 1'b1;
            hit_next       = found_reg;
            data_next      = found_reg ? fval_reg : MISS_DATA;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            capacity_reg  <= CAP_RESET;
            count_reg     <= '0;
            idx_reg       <= '0;
            pv_reg        <= 1'b0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            pv_reg        <= pv_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                capacity_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        key_reg   <= key_next;
        value_reg <= value_next;
        pidx_reg  <= pidx_next;
        slot_reg  <= slot_next;
        frank_reg <= frank_next;
        fval_reg  <= fval_next;
        hit_reg   <= hit_next;
        data_reg  <= data_next;
    end

    assign out_valid = out_valid_reg;
    assign hit       = hit_reg;
    assign data      = data_reg;

    // checks
    `LKVC_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, (count_reg <= CW'(DEPTH)))
    `LKVC_ASSERT_IMP(a_insert_room, clk, rst_n, (state_reg == ST_INSERT), (count_reg < cap_eff))
    `LKVC_ASSERT_IMP(a_rank_wr_live, clk, rst_n, (rank_we && (state_reg != ST_INSERT)), (CW'(wr_addr) < count_reg))
    `LKVC_ASSERT_NXT(a_evict_shrinks, clk, rst_n, (state_reg == ST_VCOPY), (count_reg == ($past(count_reg) - CW'(1))))
    `LKVC_ASSERT_NXT(a_put_off_idle, clk, rst_n, (in_take && (cmd == CMD_PUT) && (cap_eff == '0)), (state_reg == ST_IDLE))

endmodule

// File: dv/tb_lru_key_value_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache
// self-checking bench for the lru key/value cache
// ----------------------------------------------------------------------------
// A short table of hand-picked requests is walked first, covering the key and
// value extremes, update of an existing key, a capacity lowered below the
// number of stored entries, a zero capacity and a capacity beyond the depth.
// Random phases follow, each under its own capacity, mostly drawing keys from
// a small pool so that hits, updates and evictions all happen. Every accepted
// request runs through a shadow copy of the cache, and each get result is
// compared field by field in order of arrival. Both sides idle at random.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache;
    import lkvc_pkg::*;

    localparam int DRAIN_CYCLES = 400;
    localparam int POOL_SIZE    = 20;
    localparam int NUM_PHASES   = 10;

    typedef enum logic [1:0] {
        STEP_GET,
        STEP_PUT,
        STEP_CAP
    } step_kind_t;

    typedef struct {
        step_kind_t       kind;
        logic [KEY_W-1:0] k;
        logic [VAL_W-1:0] v;
        bit               typed;
        bit               t_hit;
        logic [VAL_W-1:0] t_data;
    } step_t;

    typedef struct {
        bit               hit;
        logic [VAL_W-1:0] data;
    } lookup_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_we = 1'b0;
    logic [CAP_W-1:0] cfg_wdata = '0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    logic             cmd = CMD_GET;
    logic [KEY_W-1:0] key = '0;
    logic [VAL_W-1:0] value = '0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic             hit;
    logic [VAL_W-1:0] data;

    // expectation typed in by the table for the request on the bus
    bit               typed_on = 1'b0;
    bit               typed_hit = 1'b0;
    logic [VAL_W-1:0] typed_data = '0;

    // shadow copy of the cache
    logic [KEY_W-1:0] shadow_keys [DEPTH_DEF];
    logic [VAL_W-1:0] shadow_vals [DEPTH_DEF];
    int unsigned      shadow_rank [DEPTH_DEF];
    int unsigned      shadow_count = 0;
    int unsigned      shadow_cap = int'(CAP_RESET);

    lookup_t          lookups_due [$];
    logic [KEY_W-1:0] key_pool [POOL_SIZE];

    int               fail_count = 0;
    int               burst_left = 0;
    int               n_gets = 0;
    int               n_hits = 0;
    int               n_puts = 0;
    int               n_cfg = 0;

    bit               mon_res;
    bit               mon_hit;
    logic [VAL_W-1:0] mon_data;
    lookup_t          mon_exp;
    lookup_t          mon_new;
    int               stall_left = 0;
    int               stall_mode = 0;

    lru_key_value_cache #(
        .DEPTH(DEPTH_DEF)
    ) uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .key       (key),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .hit       (hit),
        .data      (data)
    );

    // directed table: typed expectations only where obvious
    step_t directed_steps [25] = '{
        '{STEP_GET, 32'h0000_0000, 32'h0,         1'b1, 1'b0, MISS_DATA},
        '{STEP_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
        '{STEP_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
        '{STEP_PUT, 32'h0000_0000, 32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
        '{STEP_GET, 32'h7FFF_FFFF, 32'h0,         1'b1, 1'b1, 32'h8000_0000},
        '{STEP_GET, 32'h8000_0000, 32'h0,         1'b1, 1'b1, 32'h7FFF_FFFF},
        '{STEP_PUT, 32'h7FFF_FFFF, 32'd12345,     1'b0, 1'b0, 32'h0},
        '{STEP_GET, 32'h7FFF_FFFF, 32'h0,         1'b1, 1'b1, 32'd12345},
        '{STEP_GET, 32'hFFFF_FFFF, 32'h0,         1'b1, 1'b0, MISS_DATA},
        '{STEP_CAP, 32'h0,         32'd2,         1'b0, 1'b0, 32'h0},
        '{STEP_GET, 32'h0000_0000, 32'h0,         1'b0, 1'b0, 32'h0},
        '{STEP_PUT, 32'h0000_0005, 32'd55,        1'b0, 1'b0, 32'h0},
        '{STEP_GET, 32'h8000_0000, 32'h0,         1'b0, 1'b0, 32'h0},
        '{STEP_CAP, 32'h0,         32'd0,         1'b0, 1'b0, 32'h0},
        '{STEP_GET, 32'h0000_0005, 32'h0,         1'b1, 1'b0, MISS_DATA},
        '{STEP_PUT, 32'h0000_0006, 32'd66,        1'b0, 1'b0, 32'h0},
        '{STEP_CAP, 32'h0,         32'd31,        1'b0, 1'b0, 32'h0},
        '{STEP_GET, 32'h0000_0005, 32'h0,         1'b0, 1'b0, 32'h0},
        '{STEP_GET, 32'h0000_0006, 32'h0,         1'b0, 1'b0, 32'h0},
        '{STEP_CAP, 32'h0,         32'd1,         1'b0, 1'b0, 32'h0},
        '{STEP_PUT, 32'h0000_0007, 32'd77,        1'b0, 1'b0, 32'h0},
        '{STEP_PUT, 32'h0000_0008, 32'd88,        1'b0, 1'b0, 32'h0},
        '{STEP_GET, 32'h0000_0007, 32'h0,         1'b0, 1'b0, 32'h0},
        '{STEP_GET, 32'h0000_0008, 32'h0,         1'b0, 1'b0, 32'h0},
        '{STEP_CAP, 32'h0,         32'd16,        1'b0, 1'b0, 32'h0}
    };

    // capacity settings of the random phases
    int unsigned phase_caps [NUM_PHASES] = '{16, 1, 0, 31, 5, 17, 2, 8, 16, 3};

    // clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // capacity in force, saturated at the depth
    function automatic int unsigned cap_in_force();
        return (shadow_cap > DEPTH_DEF) ? DEPTH_DEF : shadow_cap;
    endfunction

    // slot holding the key, depth if absent
    function automatic int unsigned find_entry(input logic [KEY_W-1:0] k);
        for (int unsigned i = 0; i < shadow_count; i++)
            if (shadow_keys[i] == k)
                return i;
        return DEPTH_DEF;
    endfunction

    // make an entry most recent, ageing the ones that were newer
    function automatic void touch_entry(input int unsigned slot);
        int unsigned r;
        r = shadow_rank[slot];
        for (int unsigned i = 0; i < shadow_count; i++)
            if (shadow_rank[i] < r)
                shadow_rank[i]++;
        shadow_rank[slot] = 0;
    endfunction

    // drop the oldest entry, the last slot fills the hole
    function automatic void drop_oldest();
        int unsigned victim;
        int unsigned worst;
        victim = 0;
        worst = 0;
        if (shadow_count == 0)
            return;
        for (int unsigned i = 0; i < shadow_count; i++)
        begin
            if (shadow_rank[i] >= worst)
            begin
                worst = shadow_rank[i];
                victim = i;
            end
        end
        shadow_count--;
        shadow_keys[victim] = shadow_keys[shadow_count];
        shadow_vals[victim] = shadow_vals[shadow_count];
        shadow_rank[victim] = shadow_rank[shadow_count];
    endfunction

    // apply one request to the shadow cache, returns 1 when a result is due
    function automatic bit apply_request(input logic c, input logic [KEY_W-1:0] k,
                                         input logic [VAL_W-1:0] v,
                                         output bit res_hit,
                                         output logic [VAL_W-1:0] res_data);
        int unsigned cap;
        int unsigned slot;
        cap = cap_in_force();
        res_hit = 1'b0;
        res_data = MISS_DATA;
        if (c == CMD_GET)
        begin
            if (cap == 0)
                return 1'b1;
            slot = find_entry(k);
            if (slot < DEPTH_DEF)
            begin
                touch_entry(slot);
                res_hit = 1'b1;
                res_data = shadow_vals[slot];
            end
            return 1'b1;
        end
        if (cap == 0)
            return 1'b0;
        slot = find_entry(k);
        if (slot < DEPTH_DEF)
        begin
            shadow_vals[slot] = v;
            touch_entry(slot);
            return 1'b0;
        end
        while (shadow_count >= cap)
            drop_oldest();
        for (int unsigned i = 0; i < shadow_count; i++)
            shadow_rank[i]++;
        shadow_keys[shadow_count] = k;
        shadow_vals[shadow_count] = v;
        shadow_rank[shadow_count] = 0;
        shadow_count++;
        return 1'b0;
    endfunction

    // present one request, opening a new burst after a random gap
    task automatic send_request(input logic c, input logic [KEY_W-1:0] k,
                                input logic [VAL_W-1:0] v, input bit t_on,
                                input bit t_hit, input logic [VAL_W-1:0] t_data);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid   <= 1'b1;
        cmd        <= c;
        key        <= k;
        value      <= v;
        typed_on   <= t_on;
        typed_hit  <= t_hit;
        typed_data <= t_data;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // wait for the cache to go quiet, then write the capacity
    task automatic set_capacity(input int unsigned c);
        in_valid <= 1'b0;
        while (lookups_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we     <= 1'b1;
        cfg_wdata  <= c[CAP_W-1:0];
        shadow_cap = c;
        n_cfg++;
        @(posedge clk);
        cfg_we <= 1'b0;
        burst_left = 0;
    endtask

    // receiver: stall pattern in segments of random length
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(10, 200);
        end
        stall_left--;
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= $urandom_range(0, 1);
            default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // check results, then predict for the request accepted at this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (lookups_due.size() == 0)
                begin
                    $error("unexpected result: hit %0d data %h", hit, data);
                    fail_count++;
                end
                else
                begin
                    mon_exp = lookups_due.pop_front();
                    if (hit !== mon_exp.hit)
                    begin
                        $error("hit mismatch: expected %0d, actual %0d", mon_exp.hit, hit);
                        fail_count++;
                    end
                    if (data !== mon_exp.data)
                    begin
                        $error("data mismatch: expected %h, actual %h", mon_exp.data, data);
                        fail_count++;
                    end
                    if (hit === 1'b1)
                        n_hits++;
                end
            end
            if (in_valid && in_ready)
            begin
                mon_res = apply_request(cmd, key, value, mon_hit, mon_data);
                if (cmd == CMD_GET)
                    n_gets++;
                else
                    n_puts++;
                if (mon_res)
                begin
                    if (typed_on)
                    begin
                        mon_new.hit  = typed_hit;
                        mon_new.data = typed_data;
                    end
                    else
                    begin
                        mon_new.hit  = mon_hit;
                        mon_new.data = mon_data;
                    end
                    lookups_due = {lookups_due, mon_new};
                end
            end
        end
    end

    // stimulus
    initial
    begin
        int unsigned      cap;
        int unsigned      span;
        int               items;
        int               waited;
        logic [KEY_W-1:0] k;
        logic [VAL_W-1:0] v;

        for (int i = 0; i < DEPTH_DEF; i++)
        begin
            shadow_keys[i] = '0;
            shadow_vals[i] = '0;
            shadow_rank[i] = 0;
        end
        key_pool[0] = 32'h7FFF_FFFF;
        key_pool[1] = 32'h8000_0000;
        key_pool[2] = 32'h0000_0000;
        key_pool[3] = 32'hFFFF_FFFF;
        for (int i = 4; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        // reset
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        foreach (directed_steps[i])
        begin
            if (directed_steps[i].kind == STEP_CAP)
                set_capacity(directed_steps[i].v);
            else
                send_request((directed_steps[i].kind == STEP_PUT) ? CMD_PUT : CMD_GET,
                             directed_steps[i].k, directed_steps[i].v,
                             directed_steps[i].typed, directed_steps[i].t_hit,
                             directed_steps[i].t_data);
        end

        // random phases, keys mostly from a pool a little larger than the capacity
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            set_capacity(phase_caps[p]);
            cap = cap_in_force();
            span = (cap + 3 > POOL_SIZE) ? POOL_SIZE : cap + 3;
            items = (cap == 0) ? 60 : 160;
            for (int n = 0; n < items; n++)
            begin
                k = ($urandom_range(0, 9) == 0) ? $urandom
                                                : key_pool[$urandom_range(0, span - 1)];
                case ($urandom_range(0, 15))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'hFFFF_FFFF;
                    3: v = 32'h0000_0000;
                    default: v = $urandom;
                endcase
                send_request($urandom_range(0, 1) ? CMD_PUT : CMD_GET, k, v,
                             1'b0, 1'b0, '0);
            end
        end

        // drain
        in_valid <= 1'b0;
        waited = 0;
        while (lookups_due.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (lookups_due.size() != 0)
        begin
            $error("%0d results never arrived", lookups_due.size());
            fail_count++;
        end

        $display("covered %0d gets (%0d hits) and %0d puts", n_gets, n_hits, n_puts);
        $display("across %0d capacity writes, zero and beyond-depth included", n_cfg);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // run time limit
    initial
    begin
        #15_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
